// File: design/assert_macros.svh
// Assertion macros included by the span generator.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_ALWAYS(label, clk, rst, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_ALWAYS(label, clk, rst, expr)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// File: design/dssg_pkg.sv
// Constants and types for the disc span generator.
package dssg_pkg;

  localparam int MAX_RADIUS = 31;
  localparam int COORD_BITS = 12;
  localparam int RAD_BITS   = 5;

  localparam logic [COORD_BITS-1:0] PLANE_WIDTH_RST  = COORD_BITS'(640);
  localparam logic [COORD_BITS-1:0] PLANE_HEIGHT_RST = COORD_BITS'(480);

  // configuration register indexes
  localparam logic [1:0] REG_PLANE_WIDTH  = 2'd0;
  localparam logic [1:0] REG_PLANE_HEIGHT = 2'd1;

  typedef struct packed {
    logic [COORD_BITS-1:0] row;
    logic [COORD_BITS-1:0] x_start;
    logic [COORD_BITS-1:0] x_end;
    logic [7:0]            luma;
    logic                  cwrite;
    logic [COORD_BITS-2:0] crow;
    logic [COORD_BITS-1:0] cx_start;
    logic [COORD_BITS-1:0] cx_end;
    logic [7:0]            cb;
    logic [7:0]            cr;
  } span_t;

endpackage

// File: design/disc_scanline_span_gen.sv
// Filled-disc scanline span generator: one command in, one span request per visible row out.
//
// Usage:
//   cfg_we/cfg_index/cfg_data write plane_width (index 0) and plane_height
//   (index 1); write them only while no disc is in flight.
//   A disc request is taken on in_valid && in_ready. in_ready is high only
//   while the sequencer is idle; one disc is worked at a time.
//   Each row from centre_y-r to centre_y+r that survives clipping gives one
//   span request on out_valid/out_ready, in increasing row order; the last
//   one carries last_span. A zero radius, or a disc fully off the plane,
//   gives no request at all.
// Operation:
//   The half-width is tracked incrementally by one add/compare unit. In
//   ST_ROW the sequencer either moves the half-width by one (2r unit steps
//   per disc) or settles a row; a finish state and the idle state that
//   takes the request close the disc.
//   One span is held back until the next hit or the finish state so that
//   last_span is known; a stalled receiver stalls the row walk.
// Reset: plane registers return to 640x480, the sequencer goes idle and
//   the output register empties.
module disc_scanline_span_gen (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [1:0]                     cfg_index,
  input  logic [dssg_pkg::COORD_BITS-1:0] cfg_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic signed [12:0]             centre_x,
  input  logic signed [12:0]             centre_y,
  input  logic [dssg_pkg::RAD_BITS-1:0]  radius,
  input  logic [7:0]                     fill_luma,
  input  logic                           tint_enable,
  input  logic [7:0]                     tint_cb,
  input  logic [7:0]                     tint_cr,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [dssg_pkg::COORD_BITS-1:0] span_row,
  output logic [dssg_pkg::COORD_BITS-1:0] span_x_start,
  output logic [dssg_pkg::COORD_BITS-1:0] span_x_end,
  output logic [7:0]                     span_luma,
  output logic                           chroma_write,
  output logic [dssg_pkg::COORD_BITS-2:0] chroma_row,
  output logic [dssg_pkg::COORD_BITS-1:0] chroma_x_start,
  output logic [dssg_pkg::COORD_BITS-1:0] chroma_x_end,
  output logic [7:0]                     span_cb,
  output logic [7:0]                     span_cr,
  output logic                           last_span
);
  import dssg_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_ROW  = 2'd1;
  localparam logic [1:0] ST_FIN  = 2'd2;

  // config
  logic [COORD_BITS-1:0] plane_width, plane_height;

  // sequencer and held command
  logic [1:0]          state;
  logic signed [5:0]   dy;
  logic [RAD_BITS-1:0] r;
  logic [RAD_BITS-1:0] h;
  logic [9:0]          hsq;     // h*h
  logic [9:0]          room;    // r*r - dy*dy
  logic signed [12:0]  cx, cy;
  logic [7:0]          luma, cb, cr;
  logic                tint;

  // one-deep hold for the last_span decision, plus output register
  span_t pend;
  logic  pend_valid;
  span_t outr;
  logic  out_last;

  // datapath
  logic                  dy_le0, step_up, step_dn, adjust, out_free, row_hit, row_last;
  logic                  out_push;
  logic [10:0]           up_sum;
  logic [9:0]            room_w;
  logic signed [13:0]    y, x0, x1, x0c, x1c, pw_m1;
  logic [RAD_BITS-1:0]   r_sat;
  span_t                 span_new;

  always_comb begin
    r_sat = (radius > RAD_BITS'(MAX_RADIUS)) ? RAD_BITS'(MAX_RADIUS) : radius;

    dy_le0  = dy[5] || (dy == 6'sd0);
    up_sum  = {1'b0, hsq} + {5'b0, h, 1'b1};
    step_up = dy_le0 && (up_sum <= {1'b0, room});
    step_dn = !dy_le0 && (hsq > room);
    adjust  = step_up || step_dn;
    // room for the next row: room - (2*dy + 1)
    room_w  = room - {{3{dy[5]}}, dy, 1'b1};
    row_last = (dy == $signed({1'b0, r}));

    y     = $signed({cy[12], cy}) + $signed({{8{dy[5]}}, dy});
    x0    = $signed({cx[12], cx}) - $signed({9'b0, h});
    x1    = $signed({cx[12], cx}) + $signed({9'b0, h});
    pw_m1 = $signed({2'b00, plane_width}) - 14'sd1;
    x0c   = x0[13] ? 14'sd0 : x0;
    x1c   = (x1 > pw_m1) ? pw_m1 : x1;
    row_hit = !y[13] && (y < $signed({2'b00, plane_height})) && !(x1c < x0c);

    span_new.row     = y[COORD_BITS-1:0];
    span_new.x_start = x0c[COORD_BITS-1:0];
    span_new.x_end   = x1c[COORD_BITS-1:0];
    span_new.luma    = luma;
    span_new.cwrite  = tint && !y[0];
    if (span_new.cwrite) begin
      span_new.crow     = y[COORD_BITS-1:1];
      span_new.cx_start = {x0c[COORD_BITS-1:1], 1'b0};
      span_new.cx_end   = {x1c[COORD_BITS-1:1], 1'b1};
      span_new.cb       = cb;
      span_new.cr       = cr;
    end else begin
      span_new.crow     = '0;
      span_new.cx_start = '0;
      span_new.cx_end   = '0;
      span_new.cb       = '0;
      span_new.cr       = '0;
    end

    out_free = !out_valid || out_ready;
    // a held span moves to the output register on a settled hit or at finish
    out_push = ((state == ST_ROW) && !adjust && row_hit && pend_valid && out_free) ||
               ((state == ST_FIN) && pend_valid && out_free);
  end

  assign in_ready = (state == ST_IDLE);

  // configuration writes; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      plane_width  <= PLANE_WIDTH_RST;
      plane_height <= PLANE_HEIGHT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_PLANE_WIDTH:  plane_width  <= cfg_data;
        REG_PLANE_HEIGHT: plane_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // command hold registers (payload, no reset)
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      cx   <= centre_x;
      cy   <= centre_y;
      luma <= fill_luma;
      cb   <= tint_cb;
      cr   <= tint_cr;
      tint <= tint_enable;
    end
  end

  // sequencer: each cycle in ST_ROW either steps the half-width by one,
  // or settles the current row and moves on unless a held span is stalled
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      dy         <= '0;
      r          <= '0;
      h          <= '0;
      hsq        <= '0;
      room       <= '0;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
      out_last   <= 1'b0;
    end else begin
      if (out_push)
        out_valid <= 1'b1;
      else if (out_ready)
        out_valid <= 1'b0;

      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            r    <= r_sat;
            dy   <= -$signed({1'b0, r_sat});
            h    <= '0;
            hsq  <= '0;
            room <= '0;
            if (r_sat != '0)
              state <= ST_ROW;
          end
        end
        ST_ROW: begin
          if (step_up) begin
            h   <= h + 1'b1;
            hsq <= up_sum[9:0];
          end else if (step_dn) begin
            h   <= h - 1'b1;
            hsq <= hsq - {4'b0, h - 1'b1, 1'b1};
          end else if (!(row_hit && pend_valid && !out_free)) begin
            if (row_hit) begin
              if (pend_valid) begin
                outr     <= pend;
                out_last <= 1'b0;
              end
              pend       <= span_new;
              pend_valid <= 1'b1;
            end
            dy   <= dy + 6'sd1;
            room <= room_w;
            if (row_last)
              state <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (!pend_valid) begin
            state <= ST_IDLE;
          end else if (out_free) begin
            outr       <= pend;
            out_last   <= 1'b1;
            pend_valid <= 1'b0;
            state      <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign span_row       = outr.row;
  assign span_x_start   = outr.x_start;
  assign span_x_end     = outr.x_end;
  assign span_luma      = outr.luma;
  assign chroma_write   = outr.cwrite;
  assign chroma_row     = outr.crow;
  assign chroma_x_start = outr.cx_start;
  assign chroma_x_end   = outr.cx_end;
  assign span_cb        = outr.cb;
  assign span_cr        = outr.cr;
  assign last_span      = out_last;

`include "assert_macros.svh"

  // incremental square stays exact
  `ASSERT_ALWAYS(a_hsq_exact, clk, rst, hsq == ({5'b0, h} * {5'b0, h}))
  // half-width never passes the radius while walking rows
  `ASSERT_ALWAYS(a_h_bound, clk, rst, (state != ST_ROW) || (h <= r))
  // nothing is left held back once the sequencer is idle
  `ASSERT_ALWAYS(a_pend_idle, clk, rst, !((state == ST_IDLE) && pend_valid))
  // the finish cycle always returns to idle unless the receiver stalls
  `ASSERT_NEXT(a_fin_done, clk, rst, (state == ST_FIN) && out_free, state == ST_IDLE)

endmodule

// File: tb/testbench.sv
// Self-checking testbench for the filled-disc scanline span generator.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import dssg_pkg::*;

  // cfg_index values that map to no register; writes there must be dropped
  localparam logic [1:0] REG_UNMAPPED_LO = 2'd2;
  localparam logic [1:0] REG_UNMAPPED_HI = 2'd3;

  // watchdog limit for a full r=31 disc walk; stalls stretch that, this is generous
  localparam int QUIET_LIMIT   = 2000;
  // quiet time after the last span so a disc with no visible rows can finish
  localparam int SETTLE_CYCLES = 200;

  typedef struct packed {
    logic signed [12:0] cx;
    logic signed [12:0] cy;
    logic [RAD_BITS-1:0] r;
    logic [7:0]          luma;
    logic                tint;
    logic [7:0]          cb;
    logic [7:0]          cr;
  } disc_cmd_t;

  typedef struct packed {
    span_t s;
    logic  last;
  } span_rec_t;

  // directed row: typed_n < 0 means the span model supplies the expectation,
  // 0 or 1 is how many typed-in spans (typed_span below) are the expectation
  typedef struct {
    disc_cmd_t cmd;
    int        typed_n;
    span_rec_t typed_span;
  } disc_case_t;

  logic                  clk;
  logic                  rst          = 1'b1;
  logic                  cfg_we       = 1'b0;
  logic [1:0]            cfg_index    = REG_PLANE_WIDTH;
  logic [COORD_BITS-1:0] cfg_data     = '0;
  logic                  in_valid     = 1'b0;
  logic                  in_ready;
  logic signed [12:0]    centre_x     = '0;
  logic signed [12:0]    centre_y     = '0;
  logic [RAD_BITS-1:0]   radius       = '0;
  logic [7:0]            fill_luma    = '0;
  logic                  tint_enable  = 1'b0;
  logic [7:0]            tint_cb      = '0;
  logic [7:0]            tint_cr      = '0;
  logic                  out_valid;
  logic                  out_ready    = 1'b0;
  logic [COORD_BITS-1:0] span_row;
  logic [COORD_BITS-1:0] span_x_start;
  logic [COORD_BITS-1:0] span_x_end;
  logic [7:0]            span_luma;
  logic                  chroma_write;
  logic [COORD_BITS-2:0] chroma_row;
  logic [COORD_BITS-1:0] chroma_x_start;
  logic [COORD_BITS-1:0] chroma_x_end;
  logic [7:0]            span_cb;
  logic [7:0]            span_cr;
  logic                  last_span;

  // shadow of the plane registers, kept in step with every cfg write
  int unsigned plane_w = PLANE_WIDTH_RST;
  int unsigned plane_h = PLANE_HEIGHT_RST;

  span_rec_t  spans_due[$];     // spans owed by the DUT, oldest first
  disc_case_t disc_cases[$];    // directed table
  int         mismatches = 0;
  int         quiet_cycles = 0; // cycles with no request moving on either side
  int         send_idle_pct = 0;
  int         recv_idle_pct = 0;

  disc_scanline_span_gen DUT (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .centre_x       (centre_x),
    .centre_y       (centre_y),
    .radius         (radius),
    .fill_luma      (fill_luma),
    .tint_enable    (tint_enable),
    .tint_cb        (tint_cb),
    .tint_cr        (tint_cr),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .span_row       (span_row),
    .span_x_start   (span_x_start),
    .span_x_end     (span_x_end),
    .span_luma      (span_luma),
    .chroma_write   (chroma_write),
    .chroma_row     (chroma_row),
    .chroma_x_start (chroma_x_start),
    .chroma_x_end   (chroma_x_end),
    .span_cb        (span_cb),
    .span_cr        (span_cr),
    .last_span      (last_span)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic disc_cmd_t disc_cmd(int cx, int cy, int r, int luma, int tint,
                                         int cb, int cr);
    disc_cmd_t c;
    c.cx   = 13'(cx);
    c.cy   = 13'(cy);
    c.r    = RAD_BITS'(r);
    c.luma = 8'(luma);
    c.tint = 1'(tint);
    c.cb   = 8'(cb);
    c.cr   = 8'(cr);
    return c;
  endfunction

  function automatic span_rec_t typed_span(int row, int xs, int xe, int luma, int cw,
                                           int crow, int cxs, int cxe, int cb, int cr,
                                           int last);
    span_rec_t t;
    t.s.row      = COORD_BITS'(row);
    t.s.x_start  = COORD_BITS'(xs);
    t.s.x_end    = COORD_BITS'(xe);
    t.s.luma     = 8'(luma);
    t.s.cwrite   = 1'(cw);
    t.s.crow     = (COORD_BITS-1)'(crow);
    t.s.cx_start = COORD_BITS'(cxs);
    t.s.cx_end   = COORD_BITS'(cxe);
    t.s.cb       = 8'(cb);
    t.s.cr       = 8'(cr);
    t.last       = 1'(last);
    return t;
  endfunction

  function automatic void add_case(disc_cmd_t c, int n, span_rec_t t);
    disc_case_t dc;
    dc.cmd        = c;
    dc.typed_n    = n;
    dc.typed_span = t;
    disc_cases.push_back(dc);
  endfunction

  // Span model: walk dy from -r to r, half-width by integer sqrt of r*r-dy*dy,
  // clip to the plane, drop rows that vanish, tag the final survivor.
  function automatic void predict_spans(disc_cmd_t c);
    span_rec_t disc_spans[$];
    span_rec_t rec;
    int r, dy, y, h, room, x0, x1;
    r = int'(c.r);
    if (r > MAX_RADIUS) r = MAX_RADIUS;
    if (r > 0) begin
      for (dy = -r; dy <= r; dy++) begin
        y    = int'(c.cy) + dy;
        room = r * r - dy * dy;
        h    = 0;
        while ((h + 1) * (h + 1) <= room) h++;
        x0 = int'(c.cx) - h;
        x1 = int'(c.cx) + h;
        if (y < 0 || y >= int'(plane_h)) continue;
        if (x0 < 0) x0 = 0;
        if (x1 >= int'(plane_w)) x1 = int'(plane_w) - 1;
        if (x1 < x0) continue;
        rec = '0;
        rec.s.row     = COORD_BITS'(y);
        rec.s.x_start = COORD_BITS'(x0);
        rec.s.x_end   = COORD_BITS'(x1);
        rec.s.luma    = c.luma;
        // chroma only on even rows; pair range widened to whole cb/cr pairs
        if (c.tint && (y % 2 == 0)) begin
          rec.s.cwrite   = 1'b1;
          rec.s.crow     = (COORD_BITS-1)'(y >> 1);
          rec.s.cx_start = COORD_BITS'(x0 & ~1);
          rec.s.cx_end   = COORD_BITS'(x1 | 1);
          rec.s.cb       = c.cb;
          rec.s.cr       = c.cr;
        end
        disc_spans.push_back(rec);
      end
    end
    if (disc_spans.size() > 0) disc_spans[disc_spans.size()-1].last = 1'b1;
    foreach (disc_spans[i]) spans_due.push_back(disc_spans[i]);
  endfunction

  function automatic logic signed [12:0] clamp_coord(int v);
    if (v < -4096) v = -4096;
    if (v > 4095) v = 4095;
    return 13'(v);
  endfunction

  // Mostly discs near the plane so clipping on all four sides of the plane is hit;
  // one in eight uses a raw 13-bit centre to reach every coordinate bit.
  function automatic disc_case_t random_disc();
    disc_case_t dc;
    dc.typed_n    = -1;
    dc.typed_span = '0;
    dc.cmd.r      = ($urandom_range(9) == 0) ? '0 : RAD_BITS'($urandom_range(31));
    if ($urandom_range(7) == 0) begin
      dc.cmd.cx = 13'($urandom);
      dc.cmd.cy = 13'($urandom);
    end else begin
      dc.cmd.cx = clamp_coord(int'($urandom_range(plane_w + 80)) - 40);
      dc.cmd.cy = clamp_coord(int'($urandom_range(plane_h + 80)) - 40);
    end
    dc.cmd.luma = 8'($urandom);
    dc.cmd.tint = 1'($urandom_range(1));
    dc.cmd.cb   = 8'($urandom);
    dc.cmd.cr   = 8'($urandom);
    return dc;
  endfunction

  // Entered and left at a falling edge. in_valid is only lowered during a
  // gap, so back-to-back requests never see a low/high pair in one step.
  task automatic send_disc(disc_case_t dc);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid    <= 1'b1;
    centre_x    <= dc.cmd.cx;
    centre_y    <= dc.cmd.cy;
    radius      <= dc.cmd.r;
    fill_luma   <= dc.cmd.luma;
    tint_enable <= dc.cmd.tint;
    tint_cb     <= dc.cmd.cb;
    tint_cr     <= dc.cmd.cr;
    do @(posedge clk); while (!in_ready);
    if (dc.typed_n < 0) predict_spans(dc.cmd);
    else if (dc.typed_n == 1) spans_due.push_back(dc.typed_span);
    @(negedge clk);
  endtask

  // Hold off new requests until every owed span is back, then let any
  // disc with no visible rows run out before touching the registers.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (spans_due.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Caller drops cfg_we after the last write of a batch.
  task automatic write_reg(logic [1:0] idx, int unsigned value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= COORD_BITS'(value);
    case (idx)
      REG_PLANE_WIDTH:  plane_w = value & 32'hFFF;
      REG_PLANE_HEIGHT: plane_h = value & 32'hFFF;
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic set_plane(int unsigned w, int unsigned h);
    write_reg(REG_PLANE_WIDTH, w);
    write_reg(REG_PLANE_HEIGHT, h);
    cfg_we <= 1'b0;
  endtask

  task automatic run_random(int count, bit pause_mid);
    for (int i = 0; i < count; i++) begin
      // sender pressure: drain completely once mid-phase
      if (pause_mid && i == count / 2) wait_drained();
      send_disc(random_disc());
    end
  endtask

  // receiver stalls, decided fresh each cycle
  always @(negedge clk) out_ready <= ($urandom_range(99) >= recv_idle_pct);

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  // Span checker and activity counter for the watchdog.
  always @(posedge clk) begin : span_monitor
    span_rec_t want;
    if (rst) begin
      quiet_cycles <= 0;
    end else begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (out_valid && out_ready) begin
        if (spans_due.size() == 0) begin
          $error("span on row %0d with none owed", span_row);
          mismatches++;
        end else begin
          want = spans_due.pop_front();
          check_field("span_row",       want.s.row,      span_row);
          check_field("span_x_start",   want.s.x_start,  span_x_start);
          check_field("span_x_end",     want.s.x_end,    span_x_end);
          check_field("span_luma",      want.s.luma,     span_luma);
          check_field("chroma_write",   want.s.cwrite,   chroma_write);
          check_field("chroma_row",     want.s.crow,     chroma_row);
          check_field("chroma_x_start", want.s.cx_start, chroma_x_start);
          check_field("chroma_x_end",   want.s.cx_end,   chroma_x_end);
          check_field("span_cb",        want.s.cb,       span_cb);
          check_field("span_cr",        want.s.cr,       span_cr);
          check_field("last_span",      want.last,       last_span);
        end
      end
    end
  end

  // watchdog: nothing moving for too long means a hang
  initial begin
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("disc_scanline_span_gen verification failed");
    $finish;
  end

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed table, run on the reset plane of 640x480.
    // zero radius draws nothing
    add_case(disc_cmd(100, 100, 0, 8'h80, 1, 8'h10, 8'h20), 0, '0);
    // only the bottom tip lands on row 0: single one-pixel span with chroma
    add_case(disc_cmd(0, -31, 31, 8'hFF, 1, 8'hAA, 8'h55), 1,
             typed_span(0, 0, 0, 8'hFF, 1, 0, 0, 1, 8'hAA, 8'h55, 1));
    // only the top tip lands on the last row (odd, so no chroma)
    add_case(disc_cmd(639, 510, 31, 8'h00, 1, 8'hFF, 8'hFF), 1,
             typed_span(479, 639, 639, 8'h00, 0, 0, 0, 0, 0, 0, 1));
    // span entirely right of the plane after clipping
    add_case(disc_cmd(4095, -31, 31, 8'h12, 0, 8'h34, 8'h56), 0, '0);
    // span entirely left of the plane
    add_case(disc_cmd(-4096, 200, 31, 8'h12, 1, 8'h34, 8'h56), 0, '0);
    // every row above the plane / below the plane
    add_case(disc_cmd(300, -4096, 31, 8'h77, 1, 8'h01, 8'h02), 0, '0);
    add_case(disc_cmd(300, 4095, 31, 8'h77, 1, 8'h01, 8'h02), 0, '0);
    // full disc in the middle, all 63 rows
    add_case(disc_cmd(320, 240, 31, 8'hC3, 1, 8'h3C, 8'hA5), -1, '0);
    // clipped at two corners and at the left and right edges
    add_case(disc_cmd(0, 0, 31, 8'h5A, 1, 8'hF0, 8'h0F), -1, '0);
    add_case(disc_cmd(639, 479, 31, 8'hA5, 1, 8'h0F, 8'hF0), -1, '0);
    add_case(disc_cmd(-20, 250, 31, 8'h44, 0, 8'h99, 8'h66), -1, '0);
    add_case(disc_cmd(659, 250, 20, 8'h88, 1, 8'h66, 8'h99), -1, '0);
    // small discs, odd/even row starts, odd column ends
    add_case(disc_cmd(100, 101, 1, 8'h01, 0, 8'h02, 8'h03), -1, '0);
    add_case(disc_cmd(5, 300, 17, 8'h80, 1, 8'h40, 8'h20), -1, '0);
    add_case(disc_cmd(-1, 1, 2, 8'h00, 1, 8'h00, 8'h00), -1, '0);
    add_case(disc_cmd(638, 100, 3, 8'hFF, 1, 8'hFF, 8'hFF), -1, '0);

    send_idle_pct = 35;
    recv_idle_pct = 52;
    foreach (disc_cases[i]) send_disc(disc_cases[i]);

    // largest plane; unmapped indexes must leave the registers alone
    wait_drained();
    write_reg(REG_PLANE_WIDTH, 4095);
    write_reg(REG_PLANE_HEIGHT, 4095);
    write_reg(REG_UNMAPPED_LO, 0);
    write_reg(REG_UNMAPPED_HI, 4095);
    cfg_we <= 1'b0;
    run_random(20, 1'b0);

    // stalls swap sides; one-pixel plane
    wait_drained();
    send_idle_pct = 52;
    recv_idle_pct = 35;
    set_plane(1, 1);
    run_random(8, 1'b0);

    // zero width, then zero height: everything clips away
    wait_drained();
    set_plane(0, 480);
    run_random(5, 1'b0);
    wait_drained();
    set_plane(640, 0);
    run_random(5, 1'b0);

    // small plane, discs mostly straddle edges
    wait_drained();
    set_plane(64, 48);
    run_random(22, 1'b1);

    // no idling on either side
    wait_drained();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_plane($urandom_range(1, 4095), $urandom_range(1, 4095));
    run_random(20, 1'b0);
    wait_drained();
    set_plane(640, 480);
    run_random(20, 1'b0);

    wait_drained();
    if (mismatches == 0 && spans_due.size() == 0)
      $display("disc_scanline_span_gen verification clean");
    else
      $display("disc_scanline_span_gen verification failed");
    $finish;
  end

endmodule
